// File: sv/pdq_pkg.sv
// shared constants and types for the positional deque
// no dependencies; used by every module of the block
package pdq_pkg;

   localparam int CMD_BITS    = 4;
   localparam int POS_BITS    = 8;
   localparam int HDL_BITS    = 32;
   localparam int STAT_BITS   = 2;
   localparam int FILL_BITS   = 7;
   // wide enough to compare a position against any fill count
   localparam int CMP_BITS    = 9;
   localparam int GATHER_GRP  = 8;

   localparam int DEPTH_DEF       = 64;
   localparam int HANDLE_BITS_DEF = 32;

   localparam logic [CMD_BITS-1:0] CMD_PUSH_HEAD = 4'd0;
   localparam logic [CMD_BITS-1:0] CMD_PUSH_TAIL = 4'd1;
   localparam logic [CMD_BITS-1:0] CMD_PUSH_POS  = 4'd2;
   localparam logic [CMD_BITS-1:0] CMD_POP_HEAD  = 4'd3;
   localparam logic [CMD_BITS-1:0] CMD_POP_TAIL  = 4'd4;
   localparam logic [CMD_BITS-1:0] CMD_POP_POS   = 4'd5;
   localparam logic [CMD_BITS-1:0] CMD_PEEK_HEAD = 4'd6;
   localparam logic [CMD_BITS-1:0] CMD_PEEK_TAIL = 4'd7;
   localparam logic [CMD_BITS-1:0] CMD_PEEK_POS  = 4'd8;
   localparam logic [CMD_BITS-1:0] CMD_FLUSH     = 4'd9;

   localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd2;

   // what one cell loads on the next edge
   typedef enum logic [1:0] {
      MODE_HOLD  = 2'd0,
      MODE_LEFT  = 2'd1,
      MODE_NEW   = 2'd2,
      MODE_RIGHT = 2'd3
   } cell_mode_type;

endpackage

// File: sv/pdq_cell.sv
// one storage cell of the deque row
// depends on pdq_pkg for the cell mode type
module pdq_cell #(
   parameter int HANDLE_BITS = pdq_pkg::HANDLE_BITS_DEF
) (
   input  logic                   clock,
   input  pdq_pkg::cell_mode_type mode,
   input  logic [HANDLE_BITS-1:0] left_q,
   input  logic [HANDLE_BITS-1:0] right_q,
   input  logic [HANDLE_BITS-1:0] new_data,
   output logic [HANDLE_BITS-1:0] q
);
   import pdq_pkg::*;

   logic [HANDLE_BITS-1:0] data_ff;
   logic [HANDLE_BITS-1:0] data_in;

   always_comb begin
      case (mode)
         MODE_LEFT:  data_in = left_q;
         MODE_NEW:   data_in = new_data;
         MODE_RIGHT: data_in = right_q;
         default:    data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

// File: sv/pdq_gather.sv
// two-level read gather: selected cell value is or-ed within groups,
// registered, then or-ed across groups; depends on pdq_pkg
module pdq_gather #(
   parameter int DEPTH       = pdq_pkg::DEPTH_DEF,
   parameter int HANDLE_BITS = pdq_pkg::HANDLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic [DEPTH-1:0]       sel,
   input  logic [HANDLE_BITS-1:0] data [DEPTH],
   output logic [HANDLE_BITS-1:0] rd_data
);
   import pdq_pkg::*;

   localparam int NGRP = (DEPTH + GATHER_GRP - 1) / GATHER_GRP;

   logic [HANDLE_BITS-1:0] masked [NGRP*GATHER_GRP];
   logic [HANDLE_BITS-1:0] grp_in [NGRP];
   logic [HANDLE_BITS-1:0] grp_ff [NGRP];

   for (genvar j = 0; j < NGRP*GATHER_GRP; j++) begin : g_mask
      if (j < DEPTH) begin : g_real
         assign masked[j] = sel[j] ? data[j] : '0;
      end else begin : g_pad
         assign masked[j] = '0;
      end
   end

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GATHER_GRP; k++) begin
            grp_in[g] = grp_in[g] | masked[g*GATHER_GRP + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   always_comb begin
      rd_data = '0;
      for (int g = 0; g < NGRP; g++) begin
         rd_data = rd_data | grp_ff[g];
      end
   end

endmodule

// File: sv/positional_deque_top.sv
// top level of the positional deque: command decode, cell row, read gather
// depends on pdq_pkg, pdq_cell and pdq_gather
//
// A request is taken when start is high and busy is low. Every request gives
// exactly one response, strobed by rsp_valid for a single cycle; the receiver
// cannot stall it. busy stays high until the response register is loaded, so
// no new request is taken while one is in flight. A request is decoded and its
// position clamped as it is accepted; then the whole cell row shifts for an
// insert or remove while the addressed entry is caught in the first level of
// the read gather; last, the second gather level loads the response
// register. A new request may be accepted on the same edge that takes the
// response. rsp_fill_count is the entry count after the request; the handle is
// zero whenever rsp_handle_valid is low.
module positional_deque_top #(
   parameter int DEPTH       = pdq_pkg::DEPTH_DEF,
   parameter int HANDLE_BITS = pdq_pkg::HANDLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pdq_pkg::CMD_BITS-1:0]  req_cmd,
   input  logic [pdq_pkg::POS_BITS-1:0]  req_position,
   input  logic [pdq_pkg::HDL_BITS-1:0]  req_handle_in,
   output logic                          rsp_valid,
   output logic [pdq_pkg::HDL_BITS-1:0]  rsp_handle_out,
   output logic                          rsp_handle_valid,
   output logic [pdq_pkg::STAT_BITS-1:0] rsp_status,
   output logic [pdq_pkg::FILL_BITS-1:0] rsp_fill_count
);
   import pdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SHIFT  = 3'b010,
      ST_GATHER = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   state_type state_ff, state_in;

   logic accept;

   // entry count, updated on the accepting edge
   logic [CNT_W-1:0] count_ff, count_in;

   // decoded request, held until the response goes out
   op_type                 op_ff, op_in;
   logic                   read_ff, read_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [STAT_BITS-1:0]   status_ff, status_in;
   logic [HANDLE_BITS-1:0] handle_ff;

   // response registers
   logic                   rsp_valid_ff;
   logic [HDL_BITS-1:0]    rsp_handle_ff;
   logic                   rsp_hvalid_ff;
   logic [STAT_BITS-1:0]   rsp_status_ff;

   // position clamping
   logic [CMP_BITS-1:0] pos_cmp, cnt_cmp;
   logic [IDX_W-1:0]    tail_push, tail_pop, pos_push, pos_pop, pos_minus1;
   logic                is_full, is_empty;

   // cell row
   logic [HANDLE_BITS-1:0] cell_q [DEPTH];
   cell_mode_type          cell_mode [DEPTH];
   logic [DEPTH-1:0]       cell_sel;
   logic [HANDLE_BITS-1:0] rd_data;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign pos_cmp    = CMP_BITS'(req_position);
   assign cnt_cmp    = CMP_BITS'(count_ff);
   assign pos_minus1 = IDX_W'(req_position - POS_BITS'(1));
   // push at the tail sits just past the last entry; only used when not full
   assign tail_push  = IDX_W'(count_ff);
   assign tail_pop   = IDX_W'(count_ff - CNT_W'(1));

   // position 0 or 1 is the head, past the length is the tail
   always_comb begin
      if (pos_cmp <= CMP_BITS'(1)) begin
         pos_push = '0;
         pos_pop  = '0;
      end else if (pos_cmp > cnt_cmp) begin
         pos_push = tail_push;
         pos_pop  = tail_pop;
      end else begin
         pos_push = pos_minus1;
         pos_pop  = pos_minus1;
      end
   end

   // command decode
   always_comb begin
      op_in     = OP_NONE;
      read_in   = 1'b0;
      idx_in    = '0;
      status_in = STAT_OK;
      count_in  = count_ff;
      unique case (req_cmd) inside
         CMD_PUSH_HEAD, CMD_PUSH_TAIL, CMD_PUSH_POS: begin
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               op_in    = OP_INSERT;
               count_in = count_ff + CNT_W'(1);
               if (req_cmd == CMD_PUSH_HEAD) begin
                  idx_in = '0;
               end else if (req_cmd == CMD_PUSH_TAIL) begin
                  idx_in = tail_push;
               end else begin
                  idx_in = pos_push;
               end
            end
         end
         CMD_POP_HEAD, CMD_POP_TAIL, CMD_POP_POS,
         CMD_PEEK_HEAD, CMD_PEEK_TAIL, CMD_PEEK_POS: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
            end else begin
               read_in = 1'b1;
               // pops also remove the entry they read
               if (req_cmd == CMD_POP_HEAD || req_cmd == CMD_POP_TAIL ||
                   req_cmd == CMD_POP_POS) begin
                  op_in    = OP_REMOVE;
                  count_in = count_ff - CNT_W'(1);
               end
               if (req_cmd == CMD_POP_HEAD || req_cmd == CMD_PEEK_HEAD) begin
                  idx_in = '0;
               end else if (req_cmd == CMD_POP_TAIL || req_cmd == CMD_PEEK_TAIL) begin
                  idx_in = tail_pop;
               end else begin
                  idx_in = pos_pop;
               end
            end
         end
         CMD_FLUSH: begin
            count_in = '0;
         end
         default: begin
            // undefined commands leave the store alone
         end
      endcase
   end

   // sequencer: decode, shift plus first gather level, second gather level
   always_comb begin
      unique case (state_ff)
         ST_IDLE:   state_in = accept ? ST_SHIFT : ST_IDLE;
         ST_SHIFT:  state_in = ST_GATHER;
         ST_GATHER: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_GATHER);
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // request payload, captured on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_in;
         read_ff   <= read_in;
         idx_ff    <= idx_in;
         status_ff <= status_in;
         handle_ff <= HANDLE_BITS'(req_handle_in);
      end
   end

   // response capture at the end of the gather
   always_ff @(posedge clock) begin
      if (state_ff == ST_GATHER) begin
         rsp_handle_ff <= HDL_BITS'(rd_data);
         rsp_hvalid_ff <= read_ff;
         rsp_status_ff <= status_ff;
      end
   end

   // per-cell control: entries after an insert point move one place up,
   // entries from a remove point on take their upper neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_row
      always_comb begin
         cell_mode[i] = MODE_HOLD;
         if (state_ff == ST_SHIFT) begin
            if (op_ff == OP_INSERT) begin
               if (IDX_W'(i) == idx_ff) begin
                  cell_mode[i] = MODE_NEW;
               end else if (IDX_W'(i) > idx_ff) begin
                  cell_mode[i] = MODE_LEFT;
               end
            end else if (op_ff == OP_REMOVE) begin
               if (IDX_W'(i) >= idx_ff) begin
                  cell_mode[i] = MODE_RIGHT;
               end
            end
         end
      end

      // the gather samples the row before this cycle's shift lands
      assign cell_sel[i] = (state_ff == ST_SHIFT) && read_ff && (IDX_W'(i) == idx_ff);

      pdq_cell #(
         .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
         .clock    (clock),
         .mode     (cell_mode[i]),
         .left_q   ((i == 0) ? handle_ff : cell_q[(i == 0) ? 0 : i-1]),
         .right_q  ((i == DEPTH-1) ? cell_q[i] : cell_q[(i == DEPTH-1) ? i : i+1]),
         .new_data (handle_ff),
         .q        (cell_q[i])
      );
   end

   pdq_gather #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_gather (
      .clock   (clock),
      .sel     (cell_sel),
      .data    (cell_q),
      .rd_data (rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_handle_out   = rsp_handle_ff;
   assign rsp_handle_valid = rsp_hvalid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fill_count   = FILL_BITS'(count_ff);

   // response strobe follows the gather cycle
   a_rsp_after_gather: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GATHER) |=> rsp_valid)
      else $error("response strobe missing after gather");

   // count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   // a full status only when the store really is full
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |-> is_full)
      else $error("full status with room left");

   // an empty status only with an empty store
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_EMPTY) |-> is_empty && !rsp_handle_valid)
      else $error("empty status with entries present");

   // a delivered handle always comes with an ok status
   a_handle_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_handle_valid) |-> (rsp_status == STAT_OK))
      else $error("handle delivered with error status");

endmodule
